FILE: design/gsyc_pkg.sv
// Shared constants and types for the gated slew-limited yaw controller.
`timescale 1ns / 1ps
package gsyc_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_MIN_CONF   = 3'd0;
    localparam logic [2:0] CFG_MAX_AGE    = 3'd1;
    localparam logic [2:0] CFG_YAW_GAIN   = 3'd2;
    localparam logic [2:0] CFG_MAX_RATE   = 3'd3;
    localparam logic [2:0] CFG_MAX_ACCEL  = 3'd4;
    localparam logic [2:0] CFG_FWD_SPEED  = 3'd5;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [10:0] RST_MIN_CONF  = 11'd512;
    localparam logic [15:0] RST_MAX_AGE   = 16'd200;
    localparam logic [15:0] RST_YAW_GAIN  = 16'd256;
    localparam logic [14:0] RST_MAX_RATE  = 15'd4096;
    localparam logic [15:0] RST_MAX_ACCEL = 16'd4096;
    localparam logic [15:0] RST_FWD_SPEED = 16'd256;

    // Interval is clamped to 26 bits: past that the slew bound exceeds any
    // possible rate step, so the clamp cannot bind.
    localparam int DT_W    = 26;
    // floor(x / 1000) = (x * RECIP) >> RECIP_SH, exact for x < 2**26
    localparam int RECIP_W  = 27;
    localparam logic [RECIP_W-1:0] RECIP = 27'd68719477;
    localparam int RECIP_SH = 36;
    localparam int DELTA_W  = 17;

    typedef struct packed {
        logic             cmd_ok;
        logic [10:0]      conf;
        logic [DT_W-1:0]  dt;
    } t_gate_res;

endpackage

FILE: design/gsyc_gate.sv
// Command gating: health/match/confidence/age checks and clamped interval.
`timescale 1ns / 1ps
module gsyc_gate (
    input  logic                  i_healthy,
    input  logic                  i_match_ok,
    input  logic [10:0]           i_match_confidence,
    input  logic [10:0]           i_route_confidence,
    input  logic [31:0]           i_match_time,
    input  logic [31:0]           i_now_time,
    input  logic [10:0]           i_min_confidence,
    input  logic [15:0]           i_max_match_age,
    input  logic [31:0]           i_last_time,
    output gsyc_pkg::t_gate_res   o_res
);
    logic [10:0] conf;
    logic [32:0] age;
    logic [32:0] dt_raw;
    logic        age_bad;

    always_comb begin
        conf    = (i_match_confidence < i_route_confidence) ?
                  i_match_confidence : i_route_confidence;
        // 33-bit differences: bit 32 set means negative
        age     = {1'b0, i_now_time} - {1'b0, i_match_time};
        age_bad = age[32] || (age[31:0] > {16'b0, i_max_match_age});
        dt_raw  = {1'b0, i_now_time} - {1'b0, i_last_time};

        o_res.conf   = conf;
        o_res.cmd_ok = i_healthy && i_match_ok && !(conf < i_min_confidence) && !age_bad;
        if (dt_raw[32]) begin
            o_res.dt = '0;
        end else if (|dt_raw[31:gsyc_pkg::DT_W]) begin
            o_res.dt = '1;
        end else begin
            o_res.dt = dt_raw[gsyc_pkg::DT_W-1:0];
        end
    end
endmodule

FILE: design/gated_slew_limited_yaw_control.sv
// Top level of the gated, slew-limited proportional yaw controller.
//
// Channel  Dir  Handshake                    Payload
// -------  ---  ---------------------------  ----------------------------------
// in       in   i_in_valid / o_in_ready      direction error, match flag/conf,
//                                            route conf, timestamps, health
// out      out  o_out_valid / i_out_ready    cmd_valid, yaw_rate, speed_out,
//                                            confidence_out, cmd_time
// cfg      in   i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// One request per cycle sustained while the output is not stalled. Five
// register stages: stage 1 to stage 4, then the result register. Two loops:
// have_last/last_time at the stage 1 gate, and last_rate feeding the final
// clamp in stage 4. The interval multiply and the divide by 1000 sit in
// stages 2 and 3, ahead of the clamp.
// Reset (synchronous, active low) empties all stages and loads the register
// defaults. A stalled output holds each stage that is full; bubbles collapse.
`timescale 1ns / 1ps
module gated_slew_limited_yaw_control (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [gsyc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [gsyc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request in
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [15:0]                i_direction_error,
    input  logic                              i_match_ok,
    input  logic [10:0]                       i_match_confidence,
    input  logic [10:0]                       i_route_confidence,
    input  logic [31:0]                       i_match_time,
    input  logic [31:0]                       i_now_time,
    input  logic                              i_system_ready,
    input  logic                              i_camera_good,
    input  logic                              i_link_good,
    input  logic                              i_nav_good,
    // result out
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_cmd_valid,
    output logic signed [15:0]                o_yaw_rate,
    output logic [15:0]                       o_speed_out,
    output logic [10:0]                       o_confidence_out,
    output logic [31:0]                       o_cmd_time
);
    localparam int DT_W    = gsyc_pkg::DT_W;
    localparam int DELTA_W = gsyc_pkg::DELTA_W;
    localparam int PA_W    = DT_W + 16;
    localparam int Q_W     = DT_W + gsyc_pkg::RECIP_W;

    // ---------------- configuration registers ----------------
    logic [10:0]        r_min_conf;
    logic [15:0]        r_max_age;
    logic signed [15:0] r_yaw_gain;
    logic [14:0]        r_max_rate;
    logic [15:0]        r_max_accel;
    logic [15:0]        r_fwd_speed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_conf  <= gsyc_pkg::RST_MIN_CONF;
            r_max_age   <= gsyc_pkg::RST_MAX_AGE;
            r_yaw_gain  <= gsyc_pkg::RST_YAW_GAIN;
            r_max_rate  <= gsyc_pkg::RST_MAX_RATE;
            r_max_accel <= gsyc_pkg::RST_MAX_ACCEL;
            r_fwd_speed <= gsyc_pkg::RST_FWD_SPEED;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gsyc_pkg::CFG_MIN_CONF:  r_min_conf  <= i_cfg_data[10:0];
                gsyc_pkg::CFG_MAX_AGE:   r_max_age   <= i_cfg_data;
                gsyc_pkg::CFG_YAW_GAIN:  r_yaw_gain  <= i_cfg_data;
                gsyc_pkg::CFG_MAX_RATE:  r_max_rate  <= i_cfg_data[14:0];
                gsyc_pkg::CFG_MAX_ACCEL: r_max_accel <= i_cfg_data;
                gsyc_pkg::CFG_FWD_SPEED: r_fwd_speed <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage valids and advance enables ----------------
    logic r_v1, r_v2, r_v3, r_v4, r_ov;
    logic en1, en2, en3, en4, en_o;

    always_comb begin
        en_o = !r_ov || i_out_ready;
        en4  = !r_v4 || en_o;
        en3  = !r_v3 || en4;
        en2  = !r_v2 || en3;
        en1  = !r_v1 || en2;
    end
    assign o_in_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1)  r_v1 <= i_in_valid;
            if (en2)  r_v2 <= r_v1;
            if (en3)  r_v3 <= r_v2;
            if (en4)  r_v4 <= r_v3;
            if (en_o) r_ov <= r_v4;
        end
    end

    // ---------------- stage 1: input register, gating ----------------
    logic signed [15:0] r1_err;
    logic               r1_mok, r1_healthy;
    logic [10:0]        r1_mconf, r1_rconf;
    logic [31:0]        r1_mtime, r1_now;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_err     <= i_direction_error;
            r1_mok     <= i_match_ok;
            r1_mconf   <= i_match_confidence;
            r1_rconf   <= i_route_confidence;
            r1_mtime   <= i_match_time;
            r1_now     <= i_now_time;
            r1_healthy <= i_system_ready & i_camera_good & i_link_good & i_nav_good;
        end
    end

    // last valid command timestamp, tracked as requests leave stage 1
    logic        r_have_last;
    logic [31:0] r_last_time;
    gsyc_pkg::t_gate_res gate;

    gsyc_gate u_gate (
        .i_healthy          (r1_healthy),
        .i_match_ok         (r1_mok),
        .i_match_confidence (r1_mconf),
        .i_route_confidence (r1_rconf),
        .i_match_time       (r1_mtime),
        .i_now_time         (r1_now),
        .i_min_confidence   (r_min_conf),
        .i_max_match_age    (r_max_age),
        .i_last_time        (r_last_time),
        .o_res              (gate)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_last <= 1'b0;
            r_last_time <= '0;
        end else if (r_v1 && en2) begin
            r_have_last <= gate.cmd_ok;
            if (gate.cmd_ok) r_last_time <= r1_now;
        end
    end

    // ---------------- stage 2: both multiplies ----------------
    logic signed [15:0] r2_err;
    logic               r2_ok, r2_have;
    logic [10:0]        r2_conf;
    logic [31:0]        r2_now;
    logic [DT_W-1:0]    r2_dt;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_err  <= r1_err;
            r2_ok   <= gate.cmd_ok;
            r2_have <= r_have_last;
            r2_conf <= gate.conf;
            r2_now  <= r1_now;
            r2_dt   <= gate.dt;
        end
    end

    logic [PA_W-1:0]    s2_pa;
    logic [DT_W-1:0]    s2_pa_sat;
    logic signed [31:0] s2_prod;

    always_comb begin
        s2_pa   = {16'b0, r2_dt} * {{DT_W{1'b0}}, r_max_accel};
        // beyond 2**26 the slew bound is already wider than any rate step
        s2_pa_sat = (|s2_pa[PA_W-1:DT_W]) ? '1 : s2_pa[DT_W-1:0];
        s2_prod = 32'(r2_err) * 32'(r_yaw_gain);
    end

    // ---------------- stage 3: divide by 1000, round and saturate ----------------
    logic               r3_ok, r3_have;
    logic [10:0]        r3_conf;
    logic [31:0]        r3_now;
    logic [DT_W-1:0]    r3_pa;
    logic signed [31:0] r3_prod;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_ok   <= r2_ok;
            r3_have <= r2_have;
            r3_conf <= r2_conf;
            r3_now  <= r2_now;
            r3_pa   <= s2_pa_sat;
            r3_prod <= s2_prod;
        end
    end

    logic [Q_W-1:0]     s3_q;
    logic [DELTA_W-1:0] s3_delta;
    logic signed [31:0] s3_sum;
    logic signed [23:0] s3_round;
    logic signed [23:0] s3_max;
    logic signed [15:0] s3_rate;

    always_comb begin
        s3_q     = {{gsyc_pkg::RECIP_W{1'b0}}, r3_pa} * {{DT_W{1'b0}}, gsyc_pkg::RECIP};
        s3_delta = s3_q[gsyc_pkg::RECIP_SH +: DELTA_W];
        // round half up, Q11.20 -> Q3.12 (arithmetic shift floors)
        s3_sum   = r3_prod + 32'sd128;
        s3_round = s3_sum[31:8];
        s3_max   = signed'({9'b0, r_max_rate});
        if (s3_round > s3_max) begin
            s3_rate = s3_max[15:0];
        end else if (s3_round < -s3_max) begin
            s3_rate = 16'(-s3_max);
        end else begin
            s3_rate = s3_round[15:0];
        end
    end

    // ---------------- stage 4: slew clamp against last rate ----------------
    logic               r4_ok, r4_have;
    logic [10:0]        r4_conf;
    logic [31:0]        r4_now;
    logic [DELTA_W-1:0] r4_delta;
    logic signed [15:0] r4_rate;
    logic signed [15:0] r_last_rate;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_ok    <= r3_ok;
            r4_have  <= r3_have;
            r4_conf  <= r3_conf;
            r4_now   <= r3_now;
            r4_delta <= s3_delta;
            r4_rate  <= s3_rate;
        end
    end

    logic signed [17:0] s4_lo, s4_hi, s4_rt, s4_dl;
    logic signed [15:0] n_last_rate;

    always_comb begin
        s4_dl = signed'({1'b0, r4_delta});
        s4_lo = 18'(r_last_rate) - s4_dl;
        s4_hi = 18'(r_last_rate) + s4_dl;
        s4_rt = 18'(r4_rate);
        if (r4_have) begin
            if (s4_rt < s4_lo) s4_rt = s4_lo;
            if (s4_rt > s4_hi) s4_rt = s4_hi;
        end
        // clamped value lies between saturated rate and last rate: fits 16 bits
        n_last_rate = s4_rt[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_rate <= '0;
        end else if (r_v4 && en_o && r4_ok) begin
            r_last_rate <= n_last_rate;
        end
    end

    // ---------------- result register ----------------
    logic               r_cmd_valid;
    logic signed [15:0] r_yaw_rate;
    logic [15:0]        r_speed;
    logic [10:0]        r_conf_out;
    logic [31:0]        r_cmd_time;

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_cmd_valid <= r4_ok;
            r_yaw_rate  <= r4_ok ? n_last_rate : 16'sd0;
            r_speed     <= r4_ok ? r_fwd_speed : 16'd0;
            r_conf_out  <= r4_conf;
            r_cmd_time  <= r4_now;
        end
    end

    assign o_out_valid      = r_ov;
    assign o_cmd_valid      = r_cmd_valid;
    assign o_yaw_rate       = r_yaw_rate;
    assign o_speed_out      = r_speed;
    assign o_confidence_out = r_conf_out;
    assign o_cmd_time       = r_cmd_time;

endmodule
